// File: design/mco_pkg.sv
// Shared constants and codes for the midpoint circle outline generator.
package mco_pkg;

  // Width of the emitted pixel coordinates (two's complement).
  localparam int unsigned PIX_W = 14;

  // Pixels emitted for one octant point.
  localparam int unsigned PIX_PER_STEP = 8;
  localparam int unsigned IDX_W        = $clog2(PIX_PER_STEP);

  typedef enum logic {
    FUNC_START   = 1'b0,
    FUNC_ADVANCE = 1'b1
  } func_e;

endpackage

// File: design/mco_front.sv
// Front end: accepts items, holds the circle state and steps the octant point.
module mco_front #(
  parameter int unsigned COORD_BITS  = 12,
  parameter int unsigned RADIUS_BITS = 10,
  parameter int unsigned JOB_W       = 2 * COORD_BITS + 2 * RADIUS_BITS + 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   func_i,
  input  logic [COORD_BITS-1:0]  center_x_i,
  input  logic [COORD_BITS-1:0]  center_y_i,
  input  logic [RADIUS_BITS-1:0] radius_i,
  output logic                   job_valid_o,
  input  logic                   job_ready_i,
  output logic [JOB_W-1:0]       job_data_o
);
  import mco_pkg::*;

  localparam int unsigned DEC_W = RADIUS_BITS + 3;
  localparam int unsigned NY_W  = RADIUS_BITS + 2;

  logic [RADIUS_BITS-1:0]  offset_x_q, offset_x_d;
  logic [RADIUS_BITS-1:0]  offset_y_q, offset_y_d;
  logic [DEC_W-1:0]        decision_q, decision_d;
  logic [COORD_BITS-1:0]   center_x_q, center_x_d;
  logic [COORD_BITS-1:0]   center_y_q, center_y_d;
  logic                    active_q, active_d;

  logic                    accept;
  logic                    is_advance;
  logic                    p_neg;
  logic [RADIUS_BITS:0]    next_x;
  logic signed [NY_W-1:0]  next_y;
  logic signed [NY_W-1:0]  next_x_s;
  logic signed [NY_W-1:0]  diff;
  logic [DEC_W-1:0]        dec_incr;
  logic                    step_done;

  assign is_advance = (func_e'(func_i) == FUNC_ADVANCE);
  // Hold off every item while the queue is full.
  assign in_ready_o = job_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign p_neg    = decision_q[DEC_W-1];
  assign next_x   = {1'b0, offset_x_q} + {{RADIUS_BITS{1'b0}}, 1'b1};
  assign next_y   = $signed({2'b00, offset_y_q}) - (p_neg ? NY_W'(0) : NY_W'(1));
  assign next_x_s = $signed({1'b0, next_x});
  assign diff     = next_x_s - next_y;
  assign dec_incr = p_neg ? DEC_W'({next_x, 1'b1}) : DEC_W'({diff, 1'b1});
  assign step_done = next_x_s > next_y;

  always_comb begin
    offset_x_d = offset_x_q;
    offset_y_d = offset_y_q;
    decision_d = decision_q;
    center_x_d = center_x_q;
    center_y_d = center_y_q;
    active_d   = active_q;
    if (accept) begin
      if (!is_advance) begin
        center_x_d = center_x_i;
        center_y_d = center_y_i;
        offset_x_d = '0;
        offset_y_d = radius_i;
        decision_d = DEC_W'(1) - DEC_W'(radius_i);
        active_d   = 1'b1;
      end else if (active_q) begin
        offset_x_d = next_x[RADIUS_BITS-1:0];
        // Clamp the row offset at zero when the step would go below it.
        offset_y_d = next_y[NY_W-1] ? '0 : next_y[RADIUS_BITS-1:0];
        decision_d = decision_q + dec_incr;
        if (step_done) begin
          active_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_x_q <= '0;
      offset_y_q <= '0;
      decision_q <= '0;
      center_x_q <= '0;
      center_y_q <= '0;
      active_q   <= 1'b0;
    end else begin
      offset_x_q <= offset_x_d;
      offset_y_q <= offset_y_d;
      decision_q <= decision_d;
      center_x_q <= center_x_d;
      center_y_q <= center_y_d;
      active_q   <= active_d;
    end
  end

  // Snapshot of the point before the step goes to the back end.
  assign job_valid_o = accept && is_advance && active_q;
  assign job_data_o  = {center_x_q, center_y_q, offset_x_q, offset_y_q, step_done};

endmodule

// File: design/mco_queue.sv
// Two-entry queue between the front end and the pixel back end.
module mco_queue #(
  parameter int unsigned WIDTH = 45
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             push, pop;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      unique case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// File: design/mco_back.sv
// Back end: expands one octant point into eight mirrored pixels, one a cycle unless stalled.
module mco_back #(
  parameter int unsigned COORD_BITS  = 12,
  parameter int unsigned RADIUS_BITS = 10,
  parameter int unsigned JOB_W       = 2 * COORD_BITS + 2 * RADIUS_BITS + 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      job_valid_i,
  output logic                      job_ready_o,
  input  logic [JOB_W-1:0]          job_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [mco_pkg::PIX_W-1:0] pixel_x_o,
  output logic [mco_pkg::PIX_W-1:0] pixel_y_o,
  output logic                      last_of_step_o,
  output logic                      circle_done_o
);
  import mco_pkg::*;

  localparam int unsigned MAXB  = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;
  localparam int unsigned SUM_W = (MAXB + 2 > PIX_W) ? MAXB + 2 : PIX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PIX_PER_STEP - 1);

  logic [COORD_BITS-1:0]  cx_q, cy_q;
  logic [RADIUS_BITS-1:0] ox_q, oy_q;
  logic                   done_q;
  logic                   busy_q;
  logic [IDX_W-1:0]       idx_q;

  logic                   out_valid_q;
  logic [PIX_W-1:0]       pixel_x_q, pixel_y_q;
  logic                   last_q, done_out_q;

  logic                   emit, take;
  logic signed [SUM_W-1:0] cx_s, cy_s, offa_s, offb_s, px, py;

  assign emit        = busy_q && (!out_valid_q || out_ready_i);
  assign take        = job_valid_i && (!busy_q || (emit && idx_q == LAST_IDX));
  assign job_ready_o = take;

  // Pixels 4..7 swap the roles of the two offsets; bit 0 mirrors x, bit 1 mirrors y.
  assign cx_s   = $signed(SUM_W'(cx_q));
  assign cy_s   = $signed(SUM_W'(cy_q));
  assign offa_s = $signed(SUM_W'(idx_q[2] ? oy_q : ox_q));
  assign offb_s = $signed(SUM_W'(idx_q[2] ? ox_q : oy_q));
  assign px     = idx_q[0] ? cx_s - offa_s : cx_s + offa_s;
  assign py     = idx_q[1] ? cy_s - offb_s : cy_s + offb_s;

  always_ff @(posedge clk_i) begin
    if (take) begin
      {cx_q, cy_q, ox_q, oy_q, done_q} <= job_data_i;
    end
    if (emit) begin
      pixel_x_q  <= px[PIX_W-1:0];
      pixel_y_q  <= py[PIX_W-1:0];
      last_q     <= (idx_q == LAST_IDX);
      done_out_q <= (idx_q == LAST_IDX) && done_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      priority if (take) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (emit && idx_q == LAST_IDX) begin
        busy_q <= 1'b0;
      end else if (emit) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_x_o      = pixel_x_q;
  assign pixel_y_o      = pixel_y_q;
  assign last_of_step_o = last_q;
  assign circle_done_o  = done_out_q;

endmodule

// File: design/midpoint_circle_outline.sv
// Top level of the midpoint circle outline generator.
//
// Input channel (in_valid_i / in_ready_o): func_i = start loads center_x_i,
// center_y_i and radius_i and opens a new circle; func_i = advance emits the
// eight mirrored pixels of the current octant point and steps it. An advance
// with no circle open is taken and dropped. A start produces no pixels.
// Output channel (out_valid_o / out_ready_i): one pixel per transfer, with
// last_of_step_o on the eighth pixel of a step and circle_done_o on the last
// pixel of the circle.
// Path: the first pixel of an advance passes the queue entry, the back-end job
// register and then the output register; the rest follow one a cycle unless stalled.
// Throughput: one pixel per cycle while out_ready_i is high, set by the
// single pixel adder pair in the back end. A two-entry queue lets the front
// take further items while the back end is still emitting.
// Stalls: when out_ready_i is low the output register holds; the queue fills
// and in_ready_o drops once two steps are waiting.
// Reset: asynchronous, active low; no circle is open, the queue is empty and
// the output register holds no pixel.
module midpoint_circle_outline #(
  parameter int unsigned COORD_BITS  = 12,
  parameter int unsigned RADIUS_BITS = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      func_i,
  input  logic [COORD_BITS-1:0]     center_x_i,
  input  logic [COORD_BITS-1:0]     center_y_i,
  input  logic [RADIUS_BITS-1:0]    radius_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [mco_pkg::PIX_W-1:0] pixel_x_o,
  output logic [mco_pkg::PIX_W-1:0] pixel_y_o,
  output logic                      last_of_step_o,
  output logic                      circle_done_o
);
  import mco_pkg::*;

  localparam int unsigned JOB_W = 2 * COORD_BITS + 2 * RADIUS_BITS + 1;

  logic             fq_valid, fq_ready;
  logic [JOB_W-1:0] fq_data;
  logic             qb_valid, qb_ready;
  logic [JOB_W-1:0] qb_data;

  mco_front #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS),
    .JOB_W       (JOB_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .radius_i    (radius_i),
    .job_valid_o (fq_valid),
    .job_ready_i (fq_ready),
    .job_data_o  (fq_data)
  );

  mco_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_data_i  (fq_data),
    .rd_valid_o (qb_valid),
    .rd_ready_i (qb_ready),
    .rd_data_o  (qb_data)
  );

  mco_back #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS),
    .JOB_W       (JOB_W)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (qb_valid),
    .job_ready_o    (qb_ready),
    .job_data_i     (qb_data),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .last_of_step_o (last_of_step_o),
    .circle_done_o  (circle_done_o)
  );

endmodule

// File: verif/midpoint_circle_outline_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the midpoint circle outline generator.
module midpoint_circle_outline_tb;
  import mco_pkg::*;

  localparam int unsigned COORD_W     = 12;
  localparam int unsigned RADIUS_W    = 10;
  localparam int unsigned DEC_W       = RADIUS_W + 3;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned TAIL_ITEMS  = 40;
  localparam int unsigned RUN_ITEMS   = 250;

  typedef struct {
    func_e               fn;
    logic [COORD_W-1:0]  cx;
    logic [COORD_W-1:0]  cy;
    logic [RADIUS_W-1:0] r;
    bit                  drain;
  } circle_cmd_t;

  typedef struct {
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    logic             last;
    logic             done;
  } pixel_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  func_e               in_func   = FUNC_START;
  logic [COORD_W-1:0]  in_cx     = '0;
  logic [COORD_W-1:0]  in_cy     = '0;
  logic [RADIUS_W-1:0] in_r      = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [PIX_W-1:0]    pixel_x;
  logic [PIX_W-1:0]    pixel_y;
  logic                last_of_step;
  logic                circle_done;

  circle_cmd_t cmd_queue[$];
  pixel_t      owed_pixels[$];
  int          pixels_owed  = 0;
  bit          wind_down    = 1'b0;
  int          errors       = 0;
  int unsigned quiet_cycles = 0;

  // Circle tracker state
  logic [COORD_W-1:0]      ctr_x    = '0;
  logic [COORD_W-1:0]      ctr_y    = '0;
  logic [RADIUS_W-1:0]     arc_x    = '0;
  logic [RADIUS_W-1:0]     arc_y    = '0;
  logic signed [DEC_W-1:0] decision = '0;
  bit                      drawing  = 1'b0;

  // Idle bookkeeping for both sides
  int unsigned gap_left   = 0;
  int unsigned in_odds    = 1;
  bit          draining   = 1'b0;
  int unsigned stall_left = 0;
  int unsigned out_odds   = 1;

  midpoint_circle_outline #(
    .COORD_BITS  (COORD_W),
    .RADIUS_BITS (RADIUS_W)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .func_i         (in_func),
    .center_x_i     (in_cx),
    .center_y_i     (in_cy),
    .radius_i       (in_r),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .pixel_x_o      (pixel_x),
    .pixel_y_o      (pixel_y),
    .last_of_step_o (last_of_step),
    .circle_done_o  (circle_done)
  );

  always #5 clk = ~clk;

  task automatic flag_error(input string what);
    errors++;
    $display("ERROR at %0t: %s", $time, what);
  endtask

  // Open a circle on start; on an advance while a circle is open, owe the eight mirrored pixels and step.
  task automatic trace_outline(input func_e fn, input logic [COORD_W-1:0] cx,
                               input logic [COORD_W-1:0] cy,
                               input logic [RADIUS_W-1:0] r);
    int     ox, oy, nx, ny, p, cxi, cyi;
    int     xs[PIX_PER_STEP];
    int     ys[PIX_PER_STEP];
    pixel_t pix;
    if (fn == FUNC_START) begin
      ctr_x    = cx;
      ctr_y    = cy;
      arc_x    = '0;
      arc_y    = r;
      decision = DEC_W'(1 - int'(r));
      drawing  = 1'b1;
    end else if (drawing) begin
      cxi = int'(ctr_x);
      cyi = int'(ctr_y);
      ox  = int'(arc_x);
      oy  = int'(arc_y);
      p   = int'(decision);
      nx  = ox + 1;
      ny  = oy;
      if (p < 0) begin
        p = p + 2 * nx + 1;
      end else begin
        ny = oy - 1;
        p  = p + 2 * (nx - ny) + 1;
      end
      xs = '{cxi + ox, cxi - ox, cxi + ox, cxi - ox, cxi + oy, cxi - oy, cxi + oy, cxi - oy};
      ys = '{cyi + oy, cyi + oy, cyi - oy, cyi - oy, cyi + ox, cyi + ox, cyi - ox, cyi - ox};
      for (int k = 0; k < PIX_PER_STEP; k++) begin
        pix.px   = PIX_W'(xs[k]);
        pix.py   = PIX_W'(ys[k]);
        pix.last = (k == PIX_PER_STEP - 1);
        pix.done = (k == PIX_PER_STEP - 1) && (nx > ny);
        owed_pixels.push_back(pix);
      end
      if (nx > ny) drawing = 1'b0;
      // Clamp y at zero where the last step would take it below
      arc_x    = RADIUS_W'(nx);
      arc_y    = RADIUS_W'((ny < 0) ? 0 : ny);
      decision = DEC_W'(p);
    end
  endtask

  function automatic void add_cmd(input func_e fn, input int cx, input int cy, input int r,
                                  input bit drain = 1'b0);
    circle_cmd_t c;
    c.fn    = fn;
    c.cx    = COORD_W'(cx);
    c.cy    = COORD_W'(cy);
    c.r     = RADIUS_W'(r);
    c.drain = drain;
    cmd_queue.push_back(c);
  endfunction

  // Advance fields other than func carry noise that the block must ignore
  function automatic void add_advances(input int n);
    repeat (n) add_cmd(FUNC_ADVANCE, $urandom_range(0, 4095), $urandom_range(0, 4095),
                       $urandom_range(0, 1023));
  endfunction

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) void'(cmd_queue.pop_front());
      if ($urandom_range(0, 99) == 0) in_odds = $urandom_range(0, 3);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_queue.size() == 0) begin
          in_valid <= 1'b0;
        end else if (cmd_queue[0].drain) begin
          // Hold off until every owed pixel has been taken
          in_valid <= 1'b0;
          if (draining && pixels_owed == 0) begin
            cmd_queue[0].drain = 1'b0;
            draining = 1'b0;
          end else begin
            draining = 1'b1;
          end
        end else if (cmd_queue.size() >= TAIL_ITEMS && in_odds != 0 &&
                     $urandom_range(0, 7) < in_odds) begin
          gap_left = $urandom_range(0, 6);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_func  <= cmd_queue[0].fn;
          in_cx    <= cmd_queue[0].cx;
          in_cy    <= cmd_queue[0].cy;
          in_r     <= cmd_queue[0].r;
        end
      end
      wind_down <= (cmd_queue.size() < TAIL_ITEMS);
    end
  end

  // Monitor: check pixels, track accepted items, drive the sink stalls
  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_pixels.size() == 0) begin
          flag_error($sformatf("pixel (%0d, %0d) with none owed",
                               $signed(pixel_x), $signed(pixel_y)));
        end else begin
          want = owed_pixels.pop_front();
          if (pixel_x !== want.px)
            flag_error($sformatf("pixel_x %0d, want %0d", $signed(pixel_x), $signed(want.px)));
          if (pixel_y !== want.py)
            flag_error($sformatf("pixel_y %0d, want %0d", $signed(pixel_y), $signed(want.py)));
          if (last_of_step !== want.last)
            flag_error($sformatf("last_of_step %b, want %b", last_of_step, want.last));
          if (circle_done !== want.done)
            flag_error($sformatf("circle_done %b, want %b", circle_done, want.done));
        end
      end
      if (in_valid && in_ready) trace_outline(in_func, in_cx, in_cy, in_r);
      pixels_owed <= owed_pixels.size();
      if ($urandom_range(0, 99) == 0) out_odds = $urandom_range(0, 3);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!wind_down && out_odds != 0 && $urandom_range(0, 7) < out_odds) begin
        stall_left = $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int    item_count;
    int    pick;
    int    rad;
    int    steps;
    func_e fn;

    // Advance before any circle is open: dropped
    add_cmd(FUNC_ADVANCE, 4095, 4095, 1023);
    // Zero radius: eight copies of the centre, then an advance while idle
    add_cmd(FUNC_START, 0, 0, 0);
    add_advances(2);
    // Largest centre and radius, cut short by the next start
    add_cmd(FUNC_START, 4095, 4095, 1023);
    add_advances(3);
    add_cmd(FUNC_START, 0, 0, 1023);
    add_advances(2);
    // Radius one ends on the first step
    add_cmd(FUNC_START, 100, 200, 1);
    add_advances(1);
    add_cmd(FUNC_START, 2048, 1024, 2, 1'b1);
    add_advances(3);
    add_cmd(FUNC_START, 5, 3, 3);
    add_advances(4);

    item_count = cmd_queue.size();
    while (item_count < RUN_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        fn = $urandom_range(0, 1) ? FUNC_ADVANCE : FUNC_START;
        add_cmd(fn, $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 1023));
        item_count++;
      end else begin
        rad   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 24);
        // Roughly r / sqrt(2) steps per octant
        steps = rad * 181 / 256 + 1;
        if (rad > 64 || $urandom_range(0, 4) == 0)
          steps = $urandom_range(0, (steps < 12) ? steps : 12);
        else
          steps += $urandom_range(0, 2);
        add_cmd(FUNC_START, $urandom_range(0, 4095), $urandom_range(0, 4095), rad,
                $urandom_range(0, 19) == 0);
        add_advances(steps);
        item_count += 1 + steps;
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    do @(negedge clk);
    while (cmd_queue.size() != 0 || in_valid || pixels_owed != 0 || owed_pixels.size() != 0);
    repeat (24) @(negedge clk);

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
